// ----- rtl/accumulator_cpu_subset_executor_unit_defines.svh -----
// Assertion macros for the executor unit checker
`ifndef ACCUMULATOR_CPU_SUBSET_EXECUTOR_UNIT_DEFINES_SVH
`define ACCUMULATOR_CPU_SUBSET_EXECUTOR_UNIT_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define ACX_ASSERT_SAME(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define ACX_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/acx_pkg.sv -----
// ----------------------------------------------------------------------------
// acx_pkg
// Shared types and constants of the accumulator CPU subset executor.
// ----------------------------------------------------------------------------
package acx_pkg;
    localparam int ADDR_BITS_DEF = 16;

    typedef enum logic [4:0] {
        OP_HLT = 5'd0, OP_LDI = 5'd1, OP_LDA = 5'd2, OP_LXI = 5'd3, OP_MOV = 5'd4,
        OP_INX = 5'd5, OP_ADD = 5'd6, OP_STA = 5'd7, OP_JNZ = 5'd8, OP_CMP = 5'd9,
        OP_JNC = 5'd10, OP_MVI = 5'd11, OP_JZ = 5'd12, OP_DCR = 5'd13,
        OP_XCHG = 5'd14, OP_INR = 5'd15, OP_DCX = 5'd16, OP_PUSH = 5'd17,
        OP_POP = 5'd18, OP_XTHL = 5'd19, OP_SPHL = 5'd20, OP_JC = 5'd21
    } t_op;

    localparam logic [2:0] REG_B = 3'd0;
    localparam logic [2:0] REG_C = 3'd1;
    localparam logic [2:0] REG_H = 3'd4;
    localparam logic [2:0] REG_L = 3'd5;
    localparam logic [2:0] REG_M = 3'd6;
    localparam logic [2:0] REG_A = 3'd7;
    localparam logic [1:0] PAIR_SP = 2'd3;

    // classified instruction handed from front to back
    typedef struct packed {
        logic [4:0]  op;
        logic [2:0]  dst;
        logic [2:0]  src;
        logic [1:0]  pr;
        logic [15:0] imm;
        logic [15:0] dir;
        logic        two_mem;  // touches two memory bytes
    } t_instr;

    typedef enum logic [1:0] {ST_FIRST, ST_SECOND, ST_CLEAR} t_state;
endpackage

// ----- rtl/acx_front.sv -----
// ----------------------------------------------------------------------------
// acx_front
// Accepts input items, classifies them and queues them for execution.
// ----------------------------------------------------------------------------
module acx_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [44:0]     i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output acx_pkg::t_instr o_instr
);
    import acx_pkg::*;

    t_instr      r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_instr      w_in;
    logic        w_push, w_pop;

    // classify
    always_comb begin
        w_in.op  = i_data[4:0];
        w_in.dst = i_data[7:5];
        w_in.src = i_data[10:8];
        w_in.pr  = i_data[12:11];
        w_in.imm = i_data[28:13];
        w_in.dir = i_data[44:29];
        w_in.two_mem = ((i_data[4:0] == OP_PUSH || i_data[4:0] == OP_POP)
                        && i_data[12:11] != PAIR_SP) || i_data[4:0] == OP_XTHL;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_instr = r_q[r_rp];

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_in;
    end
endmodule

// ----- rtl/acx_back.sv -----
// ----------------------------------------------------------------------------
// acx_back
// Executes queued instructions against registers and the byte memory.
// ----------------------------------------------------------------------------
module acx_back #(
    parameter int ADDR_BITS = acx_pkg::ADDR_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  acx_pkg::t_instr i_instr,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [103:0]    o_data
);
    import acx_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0]  r_mem [DEPTH];
    logic [7:0]  r_rd;
    logic [7:0]  r_a, n_a;
    logic [7:0]  r_g [6];
    logic [7:0]  n_g [6];
    logic [15:0] r_sp, n_sp;
    logic        r_z, r_c, r_v, r_h, n_z, n_c, n_v, n_h;
    t_state      r_st, n_st;
    logic [ADDR_BITS-1:0] r_clr;
    logic        r_ov;
    logic [103:0] r_od;
    logic        n_tk;
    logic [15:0] n_tg;

    // memory port controls
    logic [ADDR_BITS-1:0] w_ra, w_wa;
    logic [7:0]  w_wd;
    logic        w_we, w_fire, w_done;
    logic [15:0] w_hl, w_pair, w_nsp;
    logic [7:0]  w_sv, w_val;
    t_op         w_op;

    assign w_op = t_op'(i_instr.op);
    assign w_hl = {r_g[REG_H], r_g[REG_L]};
    assign o_valid = r_ov;
    assign o_data  = r_od;

    function automatic logic [15:0] pair_of(input logic [1:0] p, input logic [7:0] g [6],
                                            input logic [15:0] sp);
        case (p)
            2'd0: pair_of = {g[0], g[1]};
            2'd1: pair_of = {g[2], g[3]};
            2'd2: pair_of = {g[4], g[5]};
            default: pair_of = sp;
        endcase
    endfunction

    // register view with M read from memory data
    function automatic logic [7:0] reg_of(input logic [2:0] r, input logic [7:0] g [6],
                                          input logic [7:0] a, input logic [7:0] m);
        case (r)
            REG_M: reg_of = m;
            REG_A: reg_of = a;
            default: reg_of = g[r];
        endcase
    endfunction

    // address of the FIRST-state read: every op that reads memory gets it here
    always_comb begin
        case (w_op)
            OP_LDA:  w_ra = i_instr.dir[ADDR_BITS-1:0];
            OP_POP, OP_XTHL: w_ra = r_sp[ADDR_BITS-1:0];
            default: w_ra = w_hl[ADDR_BITS-1:0];
        endcase
    end

    // main sequencer: CLEAR sweeps memory after reset, FIRST reads, SECOND executes and writes
    always_comb begin
        n_a = r_a; n_g = r_g; n_sp = r_sp;
        n_z = r_z; n_c = r_c; n_v = r_v; n_h = r_h;
        n_st = r_st; n_tk = 1'b0; n_tg = 16'd0;
        w_we = 1'b0; w_wa = '0; w_wd = 8'd0; w_fire = 1'b0; w_done = 1'b0;
        w_pair = pair_of(i_instr.pr, r_g, r_sp);
        w_sv = reg_of(i_instr.src, r_g, r_a, r_rd);
        w_nsp = r_sp; w_val = 8'd0;
        case (r_st)
            ST_CLEAR: begin
                w_we = 1'b1; w_wa = r_clr;
                if (&r_clr) n_st = ST_FIRST;
            end
            ST_FIRST: begin
                if (i_valid && (!r_ov || i_ready)) n_st = ST_SECOND;
            end
            ST_SECOND: begin
                n_st = ST_FIRST; w_done = 1'b1; w_fire = 1'b1;
                if (!r_h) begin
                    case (w_op)
                        OP_HLT: n_h = 1'b1;
                        OP_LDI, OP_MVI, OP_MOV: begin
                            w_val = (w_op == OP_MOV) ? w_sv : i_instr.imm[7:0];
                            case (i_instr.dst)
                                REG_A: n_a = w_val;
                                REG_M: begin
                                    w_we = 1'b1; w_wa = w_hl[ADDR_BITS-1:0]; w_wd = w_val;
                                end
                                default: n_g[i_instr.dst] = w_val;
                            endcase
                        end
                        OP_LDA: n_a = r_rd;
                        OP_STA: begin
                            w_we = 1'b1; w_wa = i_instr.dir[ADDR_BITS-1:0]; w_wd = r_a;
                        end
                        OP_LXI, OP_INX, OP_DCX: begin
                            w_nsp = (w_op == OP_LXI) ? i_instr.imm :
                                    (w_op == OP_INX) ? w_pair + 16'd1 :
                                    (w_pair != 16'd0) ? w_pair - 16'd1 : w_pair;
                            case (i_instr.pr)
                                2'd0: begin n_g[0] = w_nsp[15:8]; n_g[1] = w_nsp[7:0]; end
                                2'd1: begin n_g[2] = w_nsp[15:8]; n_g[3] = w_nsp[7:0]; end
                                2'd2: begin n_g[4] = w_nsp[15:8]; n_g[5] = w_nsp[7:0]; end
                                default: n_sp = w_nsp;
                            endcase
                        end
                        OP_ADD: n_a = r_a + w_sv;
                        OP_CMP: begin n_z = (w_sv == r_a); n_c = (w_sv > r_a); end
                        OP_INR, OP_DCR: begin
                            if (w_op == OP_INR) begin
                                w_val = w_sv + 8'd1; n_v = (w_sv == 8'hFF);
                            end else begin
                                w_val = w_sv - 8'd1; n_z = (w_val == 8'd0);
                            end
                            case (i_instr.src)
                                REG_A: n_a = w_val;
                                REG_M: begin
                                    w_we = 1'b1; w_wa = w_hl[ADDR_BITS-1:0]; w_wd = w_val;
                                end
                                default: n_g[i_instr.src] = w_val;
                            endcase
                        end
                        OP_JNZ: n_tk = !r_z;
                        OP_JZ:  n_tk = r_z;
                        OP_JNC: n_tk = !r_c;
                        OP_JC:  n_tk = r_c;
                        OP_XCHG: begin
                            n_g[2] = r_g[4]; n_g[3] = r_g[5];
                            n_g[4] = r_g[2]; n_g[5] = r_g[3];
                        end
                        OP_SPHL: n_sp = w_hl;
                        OP_PUSH: if (i_instr.pr != PAIR_SP) begin
                            // high byte now, low byte in the ST_CLEAR phase that follows
                            w_nsp = r_sp - 16'd1;
                            w_we = 1'b1; w_wa = w_nsp[ADDR_BITS-1:0]; w_wd = w_pair[15:8];
                        end
                        OP_XTHL: begin
                            w_we = 1'b1; w_wa = r_sp[ADDR_BITS-1:0]; w_wd = r_g[REG_L];
                            n_g[REG_L] = r_rd;
                        end
                        default: ;
                    endcase
                    // defer the result and the pop of two-byte stack ops
                    if (i_instr.two_mem) begin
                        w_done = 1'b0; w_fire = 1'b0; n_st = ST_CLEAR;
                    end
                end
                if (n_tk) n_tg = i_instr.dir;
            end
            default: n_st = ST_FIRST;
        endcase
    end

    // final phase for two-byte ops reuses ST_CLEAR after reset sweep
    logic r_swept;
    logic [ADDR_BITS-1:0] w_a2;
    logic [7:0] n3_g [6];
    logic [15:0] n3_sp;
    logic        w3;
    assign w3 = r_swept && (r_st == ST_CLEAR);
    // release the queue entry when the item retires
    assign o_ready = w_done || w3;
    always_comb begin
        n3_g = r_g; n3_sp = r_sp; w_a2 = '0;
        case (w_op)
            OP_PUSH: begin
                w_a2 = ADDR_BITS'(r_sp - 16'd2);
                n3_sp = r_sp - 16'd2;
            end
            OP_POP: begin
                w_a2 = ADDR_BITS'(r_sp + 16'd1);
                n3_sp = r_sp + 16'd2;
            end
            default: w_a2 = ADDR_BITS'(r_sp + 16'd1);
        endcase
    end

    logic [7:0] r_lo;
    always_ff @(posedge i_clk) begin
        // memory: one write, one registered read
        if (w3) begin
            if (w_op == OP_PUSH) r_mem[w_a2] <= w_pair[7:0];
            else if (w_op == OP_XTHL) r_mem[w_a2] <= r_g[REG_H];
        end else if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (r_st == ST_SECOND) r_rd <= r_mem[w_a2];
        else r_rd <= r_mem[w_ra];
        if (r_st == ST_SECOND) r_lo <= r_rd;
    end

    t_state w_nst;
    logic   w_fire3;
    assign w_nst   = w3 ? ST_FIRST : n_st;
    assign w_fire3 = w3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR; r_clr <= '0; r_swept <= 1'b0; r_ov <= 1'b0;
            r_a <= 8'd0; r_sp <= 16'd0;
            r_z <= 1'b0; r_c <= 1'b0; r_v <= 1'b0; r_h <= 1'b0;
            for (int k = 0; k < 6; k++) r_g[k] <= 8'd0;
        end else begin
            r_st <= w_nst;
            if (!r_swept) begin
                r_clr <= r_clr + ADDR_BITS'(1);
                if (&r_clr) r_swept <= 1'b1;
            end
            if (w_fire || w_fire3) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (w3) begin
                if (w_op == OP_POP) begin
                    case (i_instr.pr)
                        2'd0: begin r_g[0] <= r_rd; r_g[1] <= r_lo; end
                        2'd1: begin r_g[2] <= r_rd; r_g[3] <= r_lo; end
                        default: begin r_g[4] <= r_rd; r_g[5] <= r_lo; end
                    endcase
                end else if (w_op == OP_XTHL) r_g[REG_H] <= r_rd;
                r_sp <= (w_op == OP_XTHL) ? r_sp : n3_sp;
            end else if (r_swept) begin
                r_a <= n_a; r_g <= n_g; r_sp <= n_sp;
                r_z <= n_z; r_c <= n_c; r_v <= n_v; r_h <= n_h;
            end
        end
    end

    // result register
    logic [7:0] w_g3 [6];
    logic [15:0] w_sp3;
    always_comb begin
        w_g3 = n3_g; w_sp3 = (w_op == OP_XTHL) ? r_sp : n3_sp;
        if (w_op == OP_POP) begin
            case (i_instr.pr)
                2'd0: begin w_g3[0] = r_rd; w_g3[1] = r_lo; end
                2'd1: begin w_g3[2] = r_rd; w_g3[3] = r_lo; end
                default: begin w_g3[4] = r_rd; w_g3[5] = r_lo; end
            endcase
        end else if (w_op == OP_XTHL) w_g3[REG_H] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (w_fire3)
            r_od <= {11'd0, r_v, r_c, r_z, w_sp3, w_g3[4], w_g3[5], w_g3[2], w_g3[3],
                     w_g3[0], w_g3[1], r_a, r_h, 16'd0, 1'b0};
        else if (w_fire)
            r_od <= {11'd0, n_v, n_c, n_z, n_sp, n_g[4], n_g[5], n_g[2], n_g[3],
                     n_g[0], n_g[1], n_a, n_h, n_tg, n_tk};
    end
endmodule

// ----- rtl/accumulator_cpu_subset_executor_unit.sv -----
// ----------------------------------------------------------------------------
// accumulator_cpu_subset_executor_unit
// Executes a decoded 8-bit accumulator CPU instruction subset, one result each.
// ----------------------------------------------------------------------------
// channel   dir  contents
// s_axis    in   instruction item (operation..direct_address)
// m_axis    out  machine state after the instruction
// Most items pass through FIRST and SECOND; PUSH and POP of a register pair,
// and XTHL, also take an ST_CLEAR phase, set by the single memory port (read,
// then two byte writes or reads). After reset all 2^ADDR_BITS bytes are swept clear; the front
// queue may take up to two items meanwhile, but nothing executes. An item
// starts only once the result register is free or being taken, so a stalled
// m_axis holds the back and then fills the two-entry front queue.
module accumulator_cpu_subset_executor_unit #(
    parameter int ADDR_BITS = acx_pkg::ADDR_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: operation[4:0] dest_reg[7:5] src_reg[10:8] pair_select[12:11]
    //        immediate[28:13] direct_address[44:29], zero fill to 48
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: branch_taken[0] branch_target[16:1] halted_out[17] acc_out[25:18]
    //        bc_out[41:26] de_out[57:42] hl_out[73:58] sp_out[89:74]
    //        zero_out[90] carry_out[91] overflow_out[92], zero fill to 104
    output logic [103:0] m_axis_tdata
);
    import acx_pkg::*;

    t_instr w_instr;
    logic   w_qv, w_qr;

    acx_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata[44:0]),
        .o_valid(w_qv), .i_ready(w_qr), .o_instr(w_instr)
    );

    acx_back #(.ADDR_BITS(ADDR_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_instr(w_instr),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );
endmodule

// ----- rtl/acx_checker.sv -----
// ----------------------------------------------------------------------------
// acx_checker
// Port-level checks of the executor unit.
// ----------------------------------------------------------------------------
`include "accumulator_cpu_subset_executor_unit_defines.svh"
module acx_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);
    // stalled result holds
    `ACX_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed under stall")
    // untaken branch reports zero target
    `ACX_ASSERT_SAME(a_tgt, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[16:1] == 16'd0, "target without branch")
    // halt never clears before reset
    `ACX_ASSERT_NEXT(a_halt, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[17], !m_axis_tvalid || m_axis_tdata[17], "halt cleared")
    // padding is zero
    `ACX_ASSERT_SAME(a_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[103:93] == 11'd0, "padding set")
endmodule

bind accumulator_cpu_subset_executor_unit acx_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench of the accumulator CPU subset executor
// Drives decoded instructions and checks each result against a cycle-free
// model of the machine state: registers, stack pointer, flags, byte memory.
// ----------------------------------------------------------------------------
module tb;
    import acx_pkg::*;

    typedef struct packed {
        logic [15:0] dir;
        logic [15:0] imm;
        logic [1:0]  pr;
        logic [2:0]  src;
        logic [2:0]  dst;
        logic [4:0]  op;
    } t_instr_item;

    typedef struct packed {
        logic        ovf;
        logic        cy;
        logic        zf;
        logic [15:0] sp;
        logic [15:0] hl;
        logic [15:0] de;
        logic [15:0] bc;
        logic [7:0]  acc;
        logic        halted;
        logic [15:0] target;
        logic        taken;
    } t_cpu_state;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // tdata: operation dest_reg src_reg pair_select immediate direct_address
    logic [47:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // tdata: branch_taken branch_target halted_out acc_out bc_out de_out hl_out
    //        sp_out zero_out carry_out overflow_out
    logic [103:0] m_axis_tdata;

    accumulator_cpu_subset_executor_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // model state
    logic [7:0]  mdl_acc;
    logic [7:0]  mdl_regs [6];
    logic [15:0] mdl_sp;
    logic        mdl_zf, mdl_cy, mdl_ovf, mdl_halt;
    logic [7:0]  mdl_mem [65536];

    t_instr_item pending_items [$];
    t_cpu_state  expected_states [$];
    int          mismatch_count = 0;
    bit          stimulus_done = 1'b0;
    int          hold_off_cycles = 0;
    bit          in_taken = 1'b0;

    function automatic logic [15:0] hl_addr();
        return {mdl_regs[REG_H], mdl_regs[REG_L]};
    endfunction

    function automatic logic [7:0] read_reg(logic [2:0] r);
        if (r == REG_A) return mdl_acc;
        if (r == REG_M) return mdl_mem[hl_addr()];
        return mdl_regs[r];
    endfunction

    function automatic void write_reg(logic [2:0] r, logic [7:0] v);
        if (r == REG_A) mdl_acc = v;
        else if (r == REG_M) mdl_mem[hl_addr()] = v;
        else mdl_regs[r] = v;
    endfunction

    function automatic logic [15:0] read_pair(logic [1:0] p);
        if (p == PAIR_SP) return mdl_sp;
        return {mdl_regs[2*p], mdl_regs[2*p+1]};
    endfunction

    function automatic void write_pair(logic [1:0] p, logic [15:0] v);
        if (p == PAIR_SP) mdl_sp = v;
        else begin
            mdl_regs[2*p]   = v[15:8];
            mdl_regs[2*p+1] = v[7:0];
        end
    endfunction

    // advance the model by one instruction and return the state it reports
    function automatic t_cpu_state execute_instr(t_instr_item it);
        t_cpu_state st;
        logic        tk;
        logic [7:0]  t;
        logic [15:0] w;
        tk = 1'b0;
        if (!mdl_halt) begin
            case (it.op)
                OP_HLT: mdl_halt = 1'b1;
                OP_LDI, OP_MVI: write_reg(it.dst, it.imm[7:0]);
                OP_LDA: mdl_acc = mdl_mem[it.dir];
                OP_LXI: write_pair(it.pr, it.imm);
                OP_MOV: write_reg(it.dst, read_reg(it.src));
                OP_INX: write_pair(it.pr, read_pair(it.pr) + 16'd1);
                OP_ADD: mdl_acc = mdl_acc + read_reg(it.src);
                OP_STA: mdl_mem[it.dir] = mdl_acc;
                OP_JNZ: tk = !mdl_zf;
                OP_CMP: begin
                    t = read_reg(it.src);
                    mdl_zf = (t == mdl_acc);
                    mdl_cy = (t > mdl_acc);
                end
                OP_JNC: tk = !mdl_cy;
                OP_JZ:  tk = mdl_zf;
                OP_DCR: begin
                    t = read_reg(it.src) - 8'd1;
                    write_reg(it.src, t);
                    mdl_zf = (t == 8'd0);
                end
                OP_XCHG: begin
                    w = read_pair(2'd1);
                    write_pair(2'd1, read_pair(2'd2));
                    write_pair(2'd2, w);
                end
                OP_INR: begin
                    t = read_reg(it.src);
                    mdl_ovf = (t == 8'hFF);
                    write_reg(it.src, t + 8'd1);
                end
                OP_DCX: begin
                    w = read_pair(it.pr);
                    if (w != 16'd0) write_pair(it.pr, w - 16'd1);
                end
                OP_PUSH: if (it.pr != PAIR_SP) begin
                    w = read_pair(it.pr);
                    mdl_mem[mdl_sp - 16'd1] = w[15:8];
                    mdl_mem[mdl_sp - 16'd2] = w[7:0];
                    mdl_sp = mdl_sp - 16'd2;
                end
                OP_POP: if (it.pr != PAIR_SP) begin
                    w = {mdl_mem[mdl_sp + 16'd1], mdl_mem[mdl_sp]};
                    write_pair(it.pr, w);
                    mdl_sp = mdl_sp + 16'd2;
                end
                OP_XTHL: begin
                    t = mdl_regs[REG_L];
                    mdl_regs[REG_L] = mdl_mem[mdl_sp];
                    mdl_mem[mdl_sp] = t;
                    t = mdl_regs[REG_H];
                    mdl_regs[REG_H] = mdl_mem[mdl_sp + 16'd1];
                    mdl_mem[mdl_sp + 16'd1] = t;
                end
                OP_SPHL: mdl_sp = hl_addr();
                OP_JC:   tk = mdl_cy;
                default: ;
            endcase
        end
        st.taken  = tk;
        st.target = tk ? it.dir : 16'd0;
        st.halted = mdl_halt;
        st.acc    = mdl_acc;
        st.bc     = read_pair(2'd0);
        st.de     = read_pair(2'd1);
        st.hl     = read_pair(2'd2);
        st.sp     = mdl_sp;
        st.zf     = mdl_zf;
        st.cy     = mdl_cy;
        st.ovf    = mdl_ovf;
        return st;
    endfunction

    function automatic t_instr_item make_instr(int op, int d, int s, int p, int im, int da);
        t_instr_item it;
        it.op = 5'(op); it.dst = 3'(d); it.src = 3'(s); it.pr = 2'(p);
        it.imm = 16'(im); it.dir = 16'(da);
        return it;
    endfunction

    // mostly valid codes, rarely unused ones; random fields elsewhere
    function automatic t_instr_item random_instr(bit allow_halt);
        t_instr_item it;
        it = make_instr(0, $urandom_range(7), $urandom_range(7), $urandom_range(3),
                        $urandom_range(65535), $urandom_range(65535));
        if ($urandom_range(19) == 0) it.op = 5'($urandom_range(31, 22));
        else it.op = 5'($urandom_range(21, allow_halt ? 0 : 1));
        // keep stack and pointer in a small window so stores get read back
        if ($urandom_range(3) != 0) it.dir = {8'h80, 4'h0, it.dir[3:0]};
        if (it.op == OP_LXI && $urandom_range(1)) it.imm = {8'h80, 8'h08};
        return it;
    endfunction

    // fill the queue of pending items
    initial begin
        t_instr_item it;
        // directed part: field extremes, every code but HLT, wraps and edge cases
        pending_items.push_back(make_instr(OP_DCX, 0, 0, 0, 0, 0));       // DCX at zero
        pending_items.push_back(make_instr(OP_POP, 0, 0, 0, 0, 0));       // POP at SP zero
        pending_items.push_back(make_instr(OP_LXI, 0, 0, 0, 16'h00FF, 0));
        pending_items.push_back(make_instr(OP_INX, 0, 0, 0, 0, 0));       // carry into B
        pending_items.push_back(make_instr(OP_MVI, REG_A, 0, 0, 16'hFFFF, 0));
        pending_items.push_back(make_instr(OP_INR, 0, REG_A, 0, 0, 0));   // INR wrap
        pending_items.push_back(make_instr(OP_LDI, REG_H, 0, 0, 16'hAB12, 0));
        pending_items.push_back(make_instr(OP_LDI, REG_L, 0, 0, 16'h0034, 0));
        pending_items.push_back(make_instr(OP_MOV, REG_M, REG_M, 0, 0, 0)); // MOV M,M
        pending_items.push_back(make_instr(OP_MOV, REG_M, REG_H, 0, 0, 0));
        pending_items.push_back(make_instr(OP_ADD, 0, REG_M, 0, 0, 0));
        pending_items.push_back(make_instr(OP_STA, 0, 0, 0, 0, 16'hFFFF));
        pending_items.push_back(make_instr(OP_LDA, 0, 0, 0, 0, 16'hFFFF));
        pending_items.push_back(make_instr(OP_CMP, 0, REG_B, 0, 0, 0));
        pending_items.push_back(make_instr(OP_JC, 0, 0, 0, 0, 16'hFFFF));
        pending_items.push_back(make_instr(OP_JNC, 0, 0, 0, 0, 16'h1234));
        pending_items.push_back(make_instr(OP_JZ, 0, 0, 0, 0, 16'h5555));
        pending_items.push_back(make_instr(OP_JNZ, 0, 0, 0, 0, 16'hAAAA));
        pending_items.push_back(make_instr(OP_DCR, 0, REG_C, 0, 0, 0));
        pending_items.push_back(make_instr(OP_XCHG, 0, 0, 0, 0, 0));
        pending_items.push_back(make_instr(OP_PUSH, 0, 0, 1, 0, 0));      // PUSH down to address zero
        pending_items.push_back(make_instr(OP_PUSH, 0, 0, PAIR_SP, 0, 0));// stack pair ignored
        pending_items.push_back(make_instr(OP_XTHL, 0, 0, 0, 0, 0));
        pending_items.push_back(make_instr(OP_SPHL, 0, 0, 0, 0, 0));
        pending_items.push_back(make_instr(31, 7, 7, 3, 16'hFFFF, 16'hFFFF)); // unused code
        // random part; halt comes only near the end
        repeat (1200) pending_items.push_back(random_instr(1'b0));
        pending_items.push_back(make_instr(OP_HLT, 0, 0, 0, 0, 0));
        repeat (25) pending_items.push_back(random_instr(1'b1));
    end

    // reset, then release
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        mdl_acc = '0; mdl_sp = '0;
        mdl_zf = 0; mdl_cy = 0; mdl_ovf = 0; mdl_halt = 0;
        foreach (mdl_regs[k]) mdl_regs[k] = '0;
        foreach (mdl_mem[k]) mdl_mem[k] = '0;
    end

    // note an accepted input item at the rising edge
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // driver: bursts and gaps, change on the falling edge, hold an offered item
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                expected_states.push_back(execute_instr(pending_items.pop_front()));
            end
            if (!s_axis_tvalid || in_taken) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(40, 1);
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    burst_left--;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {3'b000, pending_items[0]};
                end else begin
                    s_axis_tvalid <= 1'b0;
                    stimulus_done = 1'b1;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off after the clearing sweep
    int rx_phase = 0;
    always @(negedge i_clk) begin
        rx_phase++;
        if (rx_phase == 68000) hold_off_cycles = 400;
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            m_axis_tready <= 1'b0;
        end else if ((rx_phase / 300) % 2 == 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ((rx_phase % 7) < 4) && ($urandom_range(4) != 0);
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_cpu_state got, exp_st;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[92:0];
            if (expected_states.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", got);
            end else begin
                exp_st = expected_states.pop_front();
                if (got !== exp_st) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", exp_st, got);
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stimulus_done);
        wait (expected_states.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_states.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // timeout: clearing sweep plus slow run, many times over
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
